[src/cce_pkg.sv]
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, character codes and the mnemonic table of the control
// character escape encoder.
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned QDEPTH     = 2;
   localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
   localparam int unsigned SLOT_W     = 6;

   localparam logic [BYTE_W-1:0] CODE_LAST_CONTROL = 8'h1F;
   localparam logic [BYTE_W-1:0] CODE_DELETE       = 8'h7F;
   localparam logic [BYTE_W-1:0] CHAR_OPEN         = 8'h3C;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE        = 8'h3E;
   localparam logic [SLOT_W-1:0] SLOT_DELETE       = 6'd32;

   // sequencer step codes
   typedef enum logic [2:0] {
      STEP_OPEN   = 3'd0,
      STEP_CHAR0  = 3'd1,
      STEP_CHAR1  = 3'd2,
      STEP_CHAR2  = 3'd3,
      STEP_CLOSE  = 3'd4
   } step_type;

   // classified item as it travels from front to back
   typedef struct packed {
      logic              esc;    // emit an escape sequence
      logic              three;  // mnemonic has three letters
      logic [BYTE_W-1:0] c0;     // raw byte, or first letter
      logic [BYTE_W-1:0] c1;
      logic [BYTE_W-1:0] c2;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // three letters packed high to low, third letter zero when unused
   function automatic logic [3*BYTE_W-1:0] mnemonic(input logic [SLOT_W-1:0] slot);
      logic [3*BYTE_W-1:0] m;
      unique case (slot)
         6'd0:  m = "NUL";
         6'd1:  m = "SOH";
         6'd2:  m = "STX";
         6'd3:  m = "ETX";
         6'd4:  m = "EOT";
         6'd5:  m = "ENQ";
         6'd6:  m = "ACK";
         6'd7:  m = "BEL";
         6'd8:  m = {"BS", 8'h00};
         6'd9:  m = {"HT", 8'h00};
         6'd10: m = {"LF", 8'h00};
         6'd11: m = {"VT", 8'h00};
         6'd12: m = {"FF", 8'h00};
         6'd13: m = {"CR", 8'h00};
         6'd14: m = {"SO", 8'h00};
         6'd15: m = {"SI", 8'h00};
         6'd16: m = "DLE";
         6'd17: m = "DC1";
         6'd18: m = "DC2";
         6'd19: m = "DC3";
         6'd20: m = "DC4";
         6'd21: m = "NAK";
         6'd22: m = "SYN";
         6'd23: m = "ETB";
         6'd24: m = "CAN";
         6'd25: m = {"EM", 8'h00};
         6'd26: m = "SUB";
         6'd27: m = "ESC";
         6'd28: m = {"FS", 8'h00};
         6'd29: m = {"GS", 8'h00};
         6'd30: m = {"RS", 8'h00};
         6'd31: m = {"US", 8'h00};
         6'd32: m = "DEL";
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

[src/cce_front.sv]
// ----------------------------------------------------------------------------
// cce_front
// Accepts input bytes and classifies them into pass-through or escape
// descriptors for the item queue.
// ----------------------------------------------------------------------------
module cce_front (
   input  logic                       req_push,
   input  logic [cce_pkg::BYTE_W-1:0] req_in_byte,
   input  cce_pkg::q_stat_type        q_stat,
   output logic                       req_full,
   output logic                       q_push,
   output cce_pkg::desc_type          q_desc
);
   import cce_pkg::*;

   logic                is_ctrl;
   logic                is_del;
   logic [SLOT_W-1:0]   slot;
   logic [3*BYTE_W-1:0] letters;

   assign is_ctrl = (req_in_byte <= CODE_LAST_CONTROL);
   assign is_del  = (req_in_byte == CODE_DELETE);
   assign slot    = is_del ? SLOT_DELETE : req_in_byte[SLOT_W-1:0];
   assign letters = mnemonic(slot);

   always_comb begin
      q_desc.esc   = is_ctrl | is_del;
      q_desc.three = (letters[BYTE_W-1:0] != '0);
      q_desc.c0    = q_desc.esc ? letters[3*BYTE_W-1:2*BYTE_W] : req_in_byte;
      q_desc.c1    = letters[2*BYTE_W-1:BYTE_W];
      q_desc.c2    = letters[BYTE_W-1:0];
   end

   assign req_full = q_stat.full;
   assign q_push   = req_push & ~q_stat.full;

endmodule

[src/cce_queue.sv]
// ----------------------------------------------------------------------------
// cce_queue
// Short item queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module cce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  cce_pkg::desc_type   q_desc,
   input  logic                q_pop,
   output cce_pkg::desc_type   q_head,
   output cce_pkg::q_stat_type q_stat
);
   import cce_pkg::*;

   desc_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign do_push      = q_push & ~q_stat.full;
   assign do_pop       = q_pop & ~q_stat.empty;
   assign q_head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_desc;
      end
   end

endmodule

[src/cce_back.sv]
// ----------------------------------------------------------------------------
// cce_back
// Sequencer that expands each queued descriptor into its result bytes and
// holds the current result in an output register.
// ----------------------------------------------------------------------------
module cce_back (
   input  logic                       clock,
   input  logic                       reset,
   input  cce_pkg::desc_type          q_head,
   input  cce_pkg::q_stat_type        q_stat,
   output logic                       q_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [cce_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last_of_run
);
   import cce_pkg::*;

   step_type          step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              load;

   // load when an item waits and the output register is free or being drained this cycle
   assign load = ~q_stat.empty & (~valid_ff | rsp_pop);

   always_comb begin
      byte_in = q_head.c0;
      last_in = 1'b1;
      if (q_head.esc) begin
         unique case (step_ff)
            STEP_OPEN: begin
               byte_in = CHAR_OPEN;
               last_in = 1'b0;
            end
            STEP_CHAR0: begin
               byte_in = q_head.c0;
               last_in = 1'b0;
            end
            STEP_CHAR1: begin
               byte_in = q_head.c1;
               last_in = 1'b0;
            end
            STEP_CHAR2: begin
               byte_in = q_head.three ? q_head.c2 : CHAR_CLOSE;
               last_in = ~q_head.three;
            end
            STEP_CLOSE: begin
               byte_in = CHAR_CLOSE;
               last_in = 1'b1;
            end
            default: begin
               byte_in = CHAR_CLOSE;
               last_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      q_pop    = load & last_in;
      step_in  = step_ff;
      valid_in = valid_ff & ~rsp_pop;
      if (load) begin
         valid_in = 1'b1;
         step_in  = last_in ? STEP_OPEN : step_type'(step_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_OPEN;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_empty       = ~valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[src/control_char_escape_encoder.sv]
// ----------------------------------------------------------------------------
// control_char_escape_encoder
// Replaces ASCII control codes and DEL by a bracketed mnemonic, e.g. <ESC>.
// ----------------------------------------------------------------------------
// Each input byte gives one result byte, except control codes 0x00..0x1F and
// DEL (0x7F), which give '<', their two- or three-letter mnemonic and '>' as
// four or five result bytes; the final byte of every run has last_of_run set.
// Bytes 0x80..0xFF pass through. While the result side keeps taking bytes, a
// stream of pass-through bytes flows at one item per clock, and for an escaped
// item the output sequencer emits one result byte per cycle. A pushed byte is
// written into the item queue and then into the output register before its
// result is visible. A two-entry item queue lets input be taken while the
// sequencer or the result side is stalled.
// ----------------------------------------------------------------------------
module control_char_escape_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [cce_pkg::BYTE_W-1:0] req_in_byte,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [cce_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last_of_run
);
   import cce_pkg::*;

   q_stat_type q_stat;
   desc_type   q_desc;
   desc_type   q_head;
   logic       q_push;
   logic       q_pop;

   cce_front u_front (
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .q_stat      (q_stat),
      .req_full    (req_full),
      .q_push      (q_push),
      .q_desc      (q_desc)
   );

   cce_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_desc (q_desc),
      .q_pop  (q_pop),
      .q_head (q_head),
      .q_stat (q_stat)
   );

   cce_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_stat          (q_stat),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[src/cce_checker.sv]
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks of the escape encoder, bound to the top level.
// ----------------------------------------------------------------------------
module cce_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_push,
   input logic                       req_full,
   input logic [cce_pkg::BYTE_W-1:0] req_in_byte,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic [cce_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                       rsp_last_of_run
);
   import cce_pkg::*;

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result queue not empty after reset");

   // a shown result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_last_of_run)))
      else $error("result changed while stalled");

   // inside a run only '<', capital letters and digits 1..4 appear
   a_run_chars: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last_of_run) |->
         (rsp_out_byte == CHAR_OPEN ||
          (rsp_out_byte >= 8'h41 && rsp_out_byte <= 8'h5A) ||
          (rsp_out_byte >= 8'h31 && rsp_out_byte <= 8'h34)))
      else $error("unexpected byte inside an escape run");

   // a run continues without a gap once started
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_of_run) |=> !rsp_empty)
      else $error("gap inside an escape run");

   // a multi-byte run does not restart with '<' before it ends
   a_close: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_of_run) |=>
         (rsp_out_byte != CHAR_OPEN))
      else $error("escape run restarted before it closed");

endmodule

bind control_char_escape_encoder cce_checker u_cce_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .req_in_byte     (req_in_byte),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

[tb/cce_escape_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cce_escape_checker
// Watches both channels of the escape encoder, predicts the bytes each
// accepted item should produce and compares them in order with the bytes
// taken from the result side.
// ----------------------------------------------------------------------------
module cce_escape_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic                       req_full,
   input  logic [cce_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                       rsp_empty,
   input  logic                       rsp_pop,
   input  logic [cce_pkg::BYTE_W-1:0] rsp_out_byte,
   input  logic                       rsp_last_of_run,
   input  logic                       drain_done,
   output int                         error_count,
   output int                         pending_count
);
   import cce_pkg::*;

   localparam int NAME_SLOTS = 33;
   localparam int DEL_SLOT   = 32;
   localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h20;

   // three characters per slot, control codes first and DEL last, space pads
   localparam logic [NAME_SLOTS*3*BYTE_W-1:0] MNEMONIC_TEXT = {
      "NULSOHSTXETXEOTENQACKBEL",
      "BS HT LF VT FF CR SO SI ",
      "DLEDC1DC2DC3DC4NAKSYNETB",
      "CANEM SUBESCFS GS RS US DEL"
   };

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } out_char_type;

   out_char_type expected_chars[$];
   logic         leftover_checked = 1'b0;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic push_char(input logic [BYTE_W-1:0] ch, input logic last);
      out_char_type c;
      c.out_byte = ch;
      c.last     = last;
      expected_chars.push_back(c);
   endtask

   // bracketed mnemonic for control codes and DEL, the byte itself otherwise
   task automatic add_escape_output(input logic [BYTE_W-1:0] b);
      int                slot;
      logic [BYTE_W-1:0] ch;
      if (b <= CODE_LAST_CONTROL || b == CODE_DELETE) begin
         slot = (b == CODE_DELETE) ? DEL_SLOT : int'(b);
         push_char(CHAR_OPEN, 1'b0);
         for (int n = 0; n < 3; n++) begin
            ch = MNEMONIC_TEXT[(NAME_SLOTS*3 - 1 - slot*3 - n)*BYTE_W +: BYTE_W];
            if (ch != PAD_CHAR)
               push_char(ch, 1'b0);
         end
         push_char(CHAR_CLOSE, 1'b1);
      end else begin
         push_char(b, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      out_char_type want;
      if (reset) begin
         error_count = 0;
      end else begin
         if (req_push && !req_full)
            add_escape_output(req_in_byte);
         if (rsp_pop && !rsp_empty) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte 0x%02h last %0b",
                                         rsp_out_byte, rsp_last_of_run));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %0b, expected %0b on byte 0x%02h",
                                            rsp_last_of_run, want.last, want.out_byte));
            end
         end
         if (drain_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (expected_chars.size() != 0)
               report_mismatch($sformatf("%0d result bytes never arrived",
                                         expected_chars.size()));
         end
      end
      pending_count = expected_chars.size();
   end

endmodule

[tb/tb_control_char_escape_encoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_control_char_escape_encoder
// Drives byte items into the escape encoder with random gaps and random
// result-side stalls: a directed set of edge bytes first, then a random
// stream weighted toward control codes. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_control_char_escape_encoder;
   import cce_pkg::*;

   localparam int RANDOM_ITEMS   = 346;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_push        = 1'b0;
   logic              req_full;
   logic [BYTE_W-1:0] req_in_byte     = '0;
   logic              rsp_empty;
   logic              rsp_pop         = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_of_run;
   logic              drain_done      = 1'b0;
   int                error_count;
   int                pending_count;
   int                idle_cycles     = 0;

   always #5 clock = ~clock;

   control_char_escape_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   cce_escape_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .drain_done      (drain_done),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return BYTE_W'($urandom_range(0, CODE_LAST_CONTROL));
      else if (r < 46)
         return CODE_DELETE;
      else if (r < 70)
         return BYTE_W'($urandom_range(CODE_LAST_CONTROL + 1, CODE_DELETE - 1));
      else if (r < 90)
         return BYTE_W'($urandom_range(CODE_DELETE + 1, 255));
      else
         return BYTE_W'($urandom_range(0, 255));
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_push    <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause_input(input int gap);
      if (gap > 0) begin
         req_push    <= 1'b0;
         req_in_byte <= BYTE_W'($urandom_range(0, 255));
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin : result_drain
      int   stall;
      int   run;
      logic steady;
      stall  = 0;
      run    = 0;
      steady = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (run == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            run    = $urandom_range(20, 100);
         end
         run--;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else begin
            rsp_pop <= 1'b1;
            if (!steady)
               stall = pick_gap();
         end
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] edge_bytes[$];
      logic              steady;
      steady = 1'b0;
      // NUL, two and three letter mnemonics, bounds of the control range, DEL,
      // high bytes, the bracket characters and alternating bit patterns
      edge_bytes = '{8'h00, 8'h01, 8'h08, 8'h09, 8'h0A, 8'h0D, 8'h19, 8'h1B, 8'h1F,
                     8'h20, 8'h3C, 8'h3E, 8'h7E, CODE_DELETE, 8'h80, 8'hFF,
                     8'h55, 8'hAA, 8'h7F, 8'h00, 8'h41, 8'h1C, 8'hC3, 8'h10};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (edge_bytes[i]) begin
         send_byte(edge_bytes[i]);
         pause_input(i < 12 ? 0 : pick_gap());
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 0)
            steady = ($urandom_range(0, 3) == 0);
         send_byte(pick_byte());
         pause_input(steady ? 0 : pick_gap());
      end
      req_push <= 1'b0;

      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      drain_done <= 1'b1;
      repeat (2) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // counts cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

[filelist.f]
src/cce_pkg.sv
src/cce_front.sv
src/cce_queue.sv
src/cce_back.sv
src/control_char_escape_encoder.sv
src/cce_checker.sv
tb/cce_escape_checker.sv
tb/tb_control_char_escape_encoder.sv
